### design/gps_pkg.sv
// Package for the graph path search unit: field widths, function and status codes,
// controller states, datapath commands and the datapath status bundle. No dependencies.
`default_nettype none
package gps_pkg;

  localparam int VW     = 4;        // vertex field width
  localparam int VCOUNT = 1 << VW;  // vertex numbers the fields can name
  localparam int NW     = VW + 1;   // counters that must hold VCOUNT itself

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [2:0] ST_PATH    = 3'd0;
  localparam logic [2:0] ST_NOPATH  = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_CLEAR, S_SEARCH,
    S_BFS_POP, S_BFS_REQ, S_BFS_CHK,
    S_DFS_TOP, S_DFS_CHK,
    S_WALK_INIT, S_WALK, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LATCH, CMD_ADD, CMD_CLEAR, CMD_NOPATH, CMD_SAME,
    CMD_BFS_INIT, CMD_BFS_POP, CMD_BFS_READ, CMD_BFS_SKIP, CMD_BFS_VISIT,
    CMD_DFS_INIT, CMD_DFS_POP, CMD_DFS_READ, CMD_DFS_VISIT,
    CMD_WALK_INIT, CMD_WALK_STEP, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic mode;       // 1 for depth-first
    logic add_ok;
    logic srch_bad;
    logic srch_same;
    logic q_more;
    logic bfs_avail;
    logic q_skip;
    logic q_goal;
    logic sp_zero;
    logic dfs_avail;
    logic walk_stop;
    logic emit_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### design/graph_path_search_unit.sv
// Top level of the graph path search unit: controller plus datapath.
// Depends on gps_pkg, gps_ctrl, gps_dpath and, through the datapath, gps_ram.
`default_nettype none
// How to use this block:
// A command beat is taken at a rising edge with start high and busy low. in_func selects
// add edge (in_vertex_a -> in_vertex_b), search (start in_vertex_a, goal in_vertex_b) or
// clear graph; the unused code is dropped without a result and busy stays low.
// Every result beat shows on the out_ ports for one cycle with out_valid high; the
// receiver cannot stall, so each beat is taken at the edge that ends its cycle. out_last
// marks the final beat of a command. A found path comes start first, one vertex a beat.
// Add and clear keep busy high for one cycle, in S_ADD or S_CLEAR, and their single beat
// is registered from that state, so it shows when busy is already low again. A search
// works from the neighbor RAM, which has one registered read port: each stored edge
// examined is read in one state and checked in the next, each vertex taken from the
// breadth-first queue passes a pop state first, and each stack pop in depth-first mode
// is a step of its own. The path is traced back a vertex a step, then emitted one vertex
// a beat. The search_mode register (0 breadth-first, 1 depth-first) is written through
// cfg_we; the user must write it only while the block is idle, the block itself does not
// enforce this. Reset clears every neighbor list, the search marks and the mode; the
// neighbor RAM itself is never cleared, since only entries below a list's degree are read.
module graph_path_search_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_func,
  input  wire logic [gps_pkg::VW-1:0] in_vertex_a,
  input  wire logic [gps_pkg::VW-1:0] in_vertex_b,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_search_mode,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [gps_pkg::VW-1:0]      out_path_vertex,
  output logic                        out_last
);

  gps_pkg::cmd_t     cmd;
  gps_pkg::dp_stat_t stat;

  // The controller sequences each command; of the datapath it sees only the status bundle.
  gps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // The datapath holds the graph, the search state and the result registers.
  gps_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .cfg_we          (cfg_we),
    .cfg_search_mode (cfg_search_mode),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_path_vertex (out_path_vertex),
    .out_last        (out_last)
  );

  // Only a path can span several beats.
  a_multi_is_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == gps_pkg::ST_PATH)
    else $error("non-path result without last");

  // Single-beat non-path results carry a zero vertex.
  a_zero_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gps_pkg::ST_PATH |-> out_path_vertex == '0 && out_last)
    else $error("non-path result with vertex or without last");

  // A real command makes the block busy in the next cycle.
  a_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == gps_pkg::FUNC_ADD || in_func == gps_pkg::FUNC_SEARCH ||
    in_func == gps_pkg::FUNC_CLEAR) |=> busy)
    else $error("accepted command did not raise busy");

  // No result beat appears in the cycle right after an idle, non-accepting cycle.
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start && !$past(busy) |=> !out_valid)
    else $error("result beat without a command");

endmodule
`default_nettype wire

### design/gps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module gps_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### design/gps_ctrl.sv
// Controller state machine of the graph path search unit.
// Depends on gps_pkg for states, commands and the status bundle.
`default_nettype none
module gps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_func,
  input  wire gps_pkg::dp_stat_t stat,
  output gps_pkg::cmd_t         cmd,
  output logic                  busy
);

  gps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = gps_pkg::CMD_NOP;
    busy      = 1'b1;
    case (state_r)
      gps_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd = gps_pkg::CMD_LATCH;
          case (in_func)
            gps_pkg::FUNC_ADD:    state_nxt = gps_pkg::S_ADD;
            gps_pkg::FUNC_SEARCH: state_nxt = gps_pkg::S_SEARCH;
            gps_pkg::FUNC_CLEAR:  state_nxt = gps_pkg::S_CLEAR;
            default:              state_nxt = gps_pkg::S_IDLE;
          endcase
        end
      end
      gps_pkg::S_ADD: begin
        cmd       = gps_pkg::CMD_ADD;
        state_nxt = gps_pkg::S_IDLE;
      end
      gps_pkg::S_CLEAR: begin
        cmd       = gps_pkg::CMD_CLEAR;
        state_nxt = gps_pkg::S_IDLE;
      end
      gps_pkg::S_SEARCH: begin
        if (stat.srch_bad) begin
          cmd       = gps_pkg::CMD_NOPATH;
          state_nxt = gps_pkg::S_IDLE;
        end else if (stat.srch_same) begin
          cmd       = gps_pkg::CMD_SAME;
          state_nxt = gps_pkg::S_IDLE;
        end else if (stat.mode) begin
          cmd       = gps_pkg::CMD_DFS_INIT;
          state_nxt = gps_pkg::S_DFS_TOP;
        end else begin
          cmd       = gps_pkg::CMD_BFS_INIT;
          state_nxt = gps_pkg::S_BFS_POP;
        end
      end
      gps_pkg::S_BFS_POP: begin
        if (stat.q_more) begin
          cmd       = gps_pkg::CMD_BFS_POP;
          state_nxt = gps_pkg::S_BFS_REQ;
        end else begin
          cmd       = gps_pkg::CMD_NOPATH;
          state_nxt = gps_pkg::S_IDLE;
        end
      end
      gps_pkg::S_BFS_REQ: begin
        if (stat.bfs_avail) begin
          cmd       = gps_pkg::CMD_BFS_READ;
          state_nxt = gps_pkg::S_BFS_CHK;
        end else begin
          state_nxt = gps_pkg::S_BFS_POP;
        end
      end
      gps_pkg::S_BFS_CHK: begin
        if (stat.q_skip) begin
          cmd       = gps_pkg::CMD_BFS_SKIP;
          state_nxt = gps_pkg::S_BFS_REQ;
        end else begin
          cmd       = gps_pkg::CMD_BFS_VISIT;
          state_nxt = stat.q_goal ? gps_pkg::S_WALK_INIT : gps_pkg::S_BFS_REQ;
        end
      end
      gps_pkg::S_DFS_TOP: begin
        if (stat.sp_zero) begin
          cmd       = gps_pkg::CMD_NOPATH;
          state_nxt = gps_pkg::S_IDLE;
        end else if (!stat.dfs_avail) begin
          cmd = gps_pkg::CMD_DFS_POP;
        end else begin
          cmd       = gps_pkg::CMD_DFS_READ;
          state_nxt = gps_pkg::S_DFS_CHK;
        end
      end
      gps_pkg::S_DFS_CHK: begin
        if (stat.q_skip) begin
          state_nxt = gps_pkg::S_DFS_TOP;
        end else begin
          cmd       = gps_pkg::CMD_DFS_VISIT;
          state_nxt = stat.q_goal ? gps_pkg::S_WALK_INIT : gps_pkg::S_DFS_TOP;
        end
      end
      gps_pkg::S_WALK_INIT: begin
        cmd       = gps_pkg::CMD_WALK_INIT;
        state_nxt = gps_pkg::S_WALK;
      end
      gps_pkg::S_WALK: begin
        if (stat.walk_stop) begin
          state_nxt = gps_pkg::S_EMIT;
        end else begin
          cmd = gps_pkg::CMD_WALK_STEP;
        end
      end
      gps_pkg::S_EMIT: begin
        cmd = gps_pkg::CMD_EMIT;
        if (stat.emit_last) begin
          state_nxt = gps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gps_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/gps_dpath.sv
// Datapath of the graph path search unit: neighbor RAM, degree counts, search marks,
// queue, stack, path buffer and result registers. Depends on gps_pkg and gps_ram.
`default_nettype none
module gps_dpath #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gps_pkg::cmd_t            cmd,
  input  wire logic [gps_pkg::VW-1:0]   in_vertex_a,
  input  wire logic [gps_pkg::VW-1:0]   in_vertex_b,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_search_mode,
  output gps_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [gps_pkg::VW-1:0]        out_path_vertex,
  output logic                          out_last
);

  localparam int VW = gps_pkg::VW;
  localparam int VC = gps_pkg::VCOUNT;
  localparam int NW = gps_pkg::NW;
  localparam int NV = (MAX_VERTICES < VC) ? MAX_VERTICES : VC;
  localparam int DEPTH = NV * MAX_DEGREE;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam logic [DW-1:0] DMAX = DW'(MAX_DEGREE);
  localparam logic [NW-1:0] NFULL = NW'(VC);

  logic                 mode_r;
  logic [VW-1:0]        a_r, b_r, cur_r, wv_r;
  logic [DW-1:0]        deg_r [VC];
  logic [VC-1:0]        vis_r, pv_r;
  logic [VW-1:0]        pred_r [VC];
  logic [VW-1:0]        queue_r [VC];
  logic [NW-1:0]        head_r, tail_r, sp_r, n_r;
  logic [DW-1:0]        idx_r;
  logic [VW-1:0]        stk_v_r [VC];
  logic [DW-1:0]        stk_n_r [VC];
  logic [VW-1:0]        rev_r [VC];

  logic [VW-1:0] q, top_v;
  logic [DW-1:0] deg_a, top_n;
  logic [VW-1:0] top;
  logic [VW-1:0] emit_i;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  function automatic logic vin(input logic [VW-1:0] v);
    return 32'(v) < MAX_VERTICES;
  endfunction

  assign deg_a  = deg_r[a_r];
  assign top    = VW'(sp_r - NW'(1));
  assign top_v  = stk_v_r[top];
  assign top_n  = stk_n_r[top];
  // The path buffer is emitted from its newest entry, which is the start vertex.
  assign emit_i = VW'(n_r - NW'(1));

  assign ram_we    = (cmd == gps_pkg::CMD_ADD) && stat.add_ok;
  assign ram_waddr = AW'(32'(a_r) * MAX_DEGREE + 32'(deg_a));
  assign ram_raddr = (cmd == gps_pkg::CMD_BFS_READ)
                   ? AW'(32'(cur_r) * MAX_DEGREE + 32'(idx_r))
                   : AW'(32'(top_v) * MAX_DEGREE + 32'(top_n));

  gps_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_nbr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b_r),
    .raddr (ram_raddr),
    .rdata (q)
  );

  always_comb begin
    stat.mode      = mode_r;
    stat.add_ok    = vin(a_r) && vin(b_r) && (deg_a < DMAX);
    stat.srch_bad  = !vin(a_r) || !vin(b_r);
    stat.srch_same = (a_r == b_r);
    stat.q_more    = (head_r < tail_r) && (head_r < NFULL);
    stat.bfs_avail = (idx_r < deg_r[cur_r]) && (idx_r < DMAX);
    stat.q_skip    = !vin(q) || vis_r[q];
    stat.q_goal    = (q == b_r);
    stat.sp_zero   = (sp_r == '0);
    stat.dfs_avail = (top_n < deg_r[top_v]) && (top_n < DMAX);
    stat.walk_stop = (wv_r == a_r) || (n_r == NFULL) || !pv_r[wv_r];
    stat.emit_last = (n_r == NW'(1));
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      vis_r     <= '0;
      pv_r      <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      sp_r      <= '0;
      n_r       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < VC; i++) begin
        deg_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        mode_r <= cfg_search_mode;
      end
      case (cmd)
        gps_pkg::CMD_LATCH: begin
          vis_r <= '0;
          pv_r  <= '0;
        end
        gps_pkg::CMD_ADD: begin
          out_valid <= 1'b1;
          if (stat.add_ok) begin
            deg_r[a_r] <= deg_a + DW'(1);
          end
        end
        gps_pkg::CMD_CLEAR: begin
          out_valid <= 1'b1;
          for (int i = 0; i < VC; i++) begin
            deg_r[i] <= '0;
          end
        end
        gps_pkg::CMD_NOPATH, gps_pkg::CMD_SAME: begin
          out_valid <= 1'b1;
        end
        gps_pkg::CMD_BFS_INIT: begin
          vis_r[a_r] <= 1'b1;
          head_r     <= '0;
          tail_r     <= NW'(1);
        end
        gps_pkg::CMD_BFS_POP: begin
          head_r <= head_r + NW'(1);
        end
        gps_pkg::CMD_BFS_VISIT: begin
          pv_r[q] <= 1'b1;
          if (!stat.q_goal) begin
            vis_r[q] <= 1'b1;
            if (tail_r < NFULL) begin
              tail_r <= tail_r + NW'(1);
            end
          end
        end
        gps_pkg::CMD_DFS_INIT: begin
          vis_r[a_r] <= 1'b1;
          sp_r       <= NW'(1);
        end
        gps_pkg::CMD_DFS_POP: begin
          sp_r <= sp_r - NW'(1);
        end
        gps_pkg::CMD_DFS_VISIT: begin
          pv_r[q]  <= 1'b1;
          vis_r[q] <= 1'b1;
          if (sp_r < NFULL) begin
            sp_r <= sp_r + NW'(1);
          end
        end
        gps_pkg::CMD_WALK_INIT: begin
          n_r <= NW'(1);
        end
        gps_pkg::CMD_WALK_STEP: begin
          n_r <= n_r + NW'(1);
        end
        gps_pkg::CMD_EMIT: begin
          out_valid <= 1'b1;
          n_r       <= n_r - NW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd)
      gps_pkg::CMD_LATCH: begin
        a_r <= in_vertex_a;
        b_r <= in_vertex_b;
      end
      gps_pkg::CMD_ADD: begin
        out_status      <= stat.add_ok ? gps_pkg::ST_ADDED : gps_pkg::ST_DROPPED;
        out_path_vertex <= '0;
        out_last        <= 1'b1;
      end
      gps_pkg::CMD_CLEAR: begin
        out_status      <= gps_pkg::ST_CLEARED;
        out_path_vertex <= '0;
        out_last        <= 1'b1;
      end
      gps_pkg::CMD_NOPATH: begin
        out_status      <= gps_pkg::ST_NOPATH;
        out_path_vertex <= '0;
        out_last        <= 1'b1;
      end
      gps_pkg::CMD_SAME: begin
        out_status      <= gps_pkg::ST_PATH;
        out_path_vertex <= a_r;
        out_last        <= 1'b1;
      end
      gps_pkg::CMD_BFS_INIT: begin
        queue_r[0] <= a_r;
      end
      gps_pkg::CMD_BFS_POP: begin
        cur_r <= queue_r[head_r[VW-1:0]];
        idx_r <= '0;
      end
      gps_pkg::CMD_BFS_SKIP: begin
        idx_r <= idx_r + DW'(1);
      end
      gps_pkg::CMD_BFS_VISIT: begin
        pred_r[q] <= cur_r;
        idx_r     <= idx_r + DW'(1);
        if (!stat.q_goal && tail_r < NFULL) begin
          queue_r[tail_r[VW-1:0]] <= q;
        end
      end
      gps_pkg::CMD_DFS_INIT: begin
        stk_v_r[0] <= a_r;
        stk_n_r[0] <= '0;
      end
      gps_pkg::CMD_DFS_READ: begin
        stk_n_r[top] <= top_n + DW'(1);
      end
      gps_pkg::CMD_DFS_VISIT: begin
        pred_r[q] <= top_v;
        if (sp_r < NFULL) begin
          stk_v_r[sp_r[VW-1:0]] <= q;
          stk_n_r[sp_r[VW-1:0]] <= '0;
        end
      end
      gps_pkg::CMD_WALK_INIT: begin
        rev_r[0] <= b_r;
        wv_r     <= b_r;
      end
      gps_pkg::CMD_WALK_STEP: begin
        rev_r[n_r[VW-1:0]] <= pred_r[wv_r];
        wv_r               <= pred_r[wv_r];
      end
      gps_pkg::CMD_EMIT: begin
        out_status      <= gps_pkg::ST_PATH;
        out_path_vertex <= rev_r[emit_i];
        out_last        <= (n_r == NW'(1));
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### verif/gps_checker.sv
// Checker for the graph path search unit: watches the command and result channels,
// predicts every result beat and compares. Depends on gps_pkg.
`timescale 1ns / 100ps
module gps_checker (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [1:0]             in_func,
  input  wire logic [gps_pkg::VW-1:0] in_vertex_a,
  input  wire logic [gps_pkg::VW-1:0] in_vertex_b,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_search_mode,
  input  wire logic                   out_valid,
  input  wire logic [2:0]             out_status,
  input  wire logic [gps_pkg::VW-1:0] out_path_vertex,
  input  wire logic                   out_last,
  output int                          fail_count,
  output int                          pending
);
  import gps_pkg::*;

  localparam int NV = 16;
  localparam int ND = 8;

  typedef struct packed {
    logic [2:0]    status;
    logic [VW-1:0] vtx;
    logic          last;
  } beat_t;

  logic [VW-1:0] adj [NV][ND];
  int            deg [NV];
  logic          mode;
  beat_t         beat_q [$];

  assign pending = beat_q.size();

  function automatic beat_t mk(logic [2:0] st, logic [VW-1:0] v, logic l);
    beat_t b;
    b.status = st;
    b.vtx    = v;
    b.last   = l;
    return b;
  endfunction

  // Breadth-first or depth-first search; pushes the expected path or a miss.
  task automatic predict_path(int s, int t);
    int   pred [NV];
    logic seen [NV];
    int   fifo [$];
    int   stk_v [$];
    int   stk_i [$];
    int   rev [$];
    int   v, q, i;
    logic found;
    found = 0;
    foreach (pred[k]) begin
      pred[k] = -1;
      seen[k] = 0;
    end
    seen[s] = 1;
    if (!mode) begin
      fifo.push_back(s);
      while (fifo.size() > 0 && !found) begin
        v = fifo.pop_front();
        for (i = 0; i < deg[v] && !found; i++) begin
          q = adj[v][i];
          if (!seen[q]) begin
            pred[q] = v;
            if (q == t) found = 1;
            else begin
              seen[q] = 1;
              fifo.push_back(q);
            end
          end
        end
      end
    end else begin
      stk_v.push_back(s);
      stk_i.push_back(0);
      while (stk_v.size() > 0 && !found) begin
        v = stk_v[$];
        i = stk_i[$];
        if (i >= deg[v]) begin
          void'(stk_v.pop_back());
          void'(stk_i.pop_back());
        end else begin
          stk_i[$] = i + 1;
          q = adj[v][i];
          if (!seen[q]) begin
            pred[q] = v;
            seen[q] = 1;
            if (q == t) found = 1;
            else begin
              stk_v.push_back(q);
              stk_i.push_back(0);
            end
          end
        end
      end
    end
    if (!found) begin
      beat_q.push_back(mk(ST_NOPATH, '0, 1'b1));
    end else begin
      v = t;
      rev.push_front(v);
      while (v != s && rev.size() < NV && pred[v] >= 0) begin
        v = pred[v];
        rev.push_front(v);
      end
      foreach (rev[k]) beat_q.push_back(mk(ST_PATH, rev[k], k == rev.size() - 1));
    end
  endtask

  always @(posedge clk) begin
    beat_t exp_b;
    if (!rst_n) begin
      foreach (deg[k]) deg[k] = 0;
      mode = 1'b0;
      fail_count = 0;
      beat_q.delete();
    end else begin
      // A result never shows in the cycle its command is taken, so comparing first is safe.
      if (out_valid) begin
        if (beat_q.size() == 0) begin
          $display("%0t: unexpected beat status=%0d vertex=%0d last=%0b", $time,
                   out_status, out_path_vertex, out_last);
          fail_count++;
        end else begin
          exp_b = beat_q.pop_front();
          if (exp_b != {out_status, out_path_vertex, out_last}) begin
            $display("%0t: mismatch expected status=%0d vertex=%0d last=%0b, actual %0d %0d %0b",
                     $time, exp_b.status, exp_b.vtx, exp_b.last,
                     out_status, out_path_vertex, out_last);
            fail_count++;
          end
        end
      end
      if (cfg_we) mode = cfg_search_mode;
      if (start && !busy) begin
        case (in_func)
          FUNC_ADD: begin
            if (deg[in_vertex_a] >= ND) beat_q.push_back(mk(ST_DROPPED, '0, 1'b1));
            else begin
              adj[in_vertex_a][deg[in_vertex_a]] = in_vertex_b;
              deg[in_vertex_a]++;
              beat_q.push_back(mk(ST_ADDED, '0, 1'b1));
            end
          end
          FUNC_CLEAR: begin
            foreach (deg[k]) deg[k] = 0;
            beat_q.push_back(mk(ST_CLEARED, '0, 1'b1));
          end
          FUNC_SEARCH: begin
            if (in_vertex_a == in_vertex_b)
              beat_q.push_back(mk(ST_PATH, in_vertex_a, 1'b1));
            else
              predict_path(in_vertex_a, in_vertex_b);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

### verif/tb_graph_path_search_unit.sv
// Testbench top for the graph path search unit: clock, reset, command stimulus and
// verdict. Depends on gps_pkg, graph_path_search_unit and gps_checker.
`timescale 1ns / 100ps
module tb_graph_path_search_unit;
  import gps_pkg::*;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [1:0]    in_func = FUNC_CLEAR;
  logic [VW-1:0] in_vertex_a = '0;
  logic [VW-1:0] in_vertex_b = '0;
  logic          cfg_we = 1'b0;
  logic          cfg_search_mode = 1'b0;
  wire           busy, out_valid, out_last;
  wire [2:0]     out_status;
  wire [VW-1:0]  out_path_vertex;
  int            fail_count, pending;
  int            cycles = 0;

  // The cycle limit covers about 360 commands, each at the slowest search plus the largest
  // random gap, several times over.
  localparam int CYCLE_LIMIT = 1000000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  graph_path_search_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .cfg_we(cfg_we), .cfg_search_mode(cfg_search_mode),
    .out_valid(out_valid), .out_status(out_status),
    .out_path_vertex(out_path_vertex), .out_last(out_last)
  );

  gps_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .cfg_we(cfg_we), .cfg_search_mode(cfg_search_mode),
    .out_valid(out_valid), .out_status(out_status),
    .out_path_vertex(out_path_vertex), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive one command beat: busy is looked at on falling edges only, and once it is low
  // the next rising edge accepts the beat. Then wait a random gap (zero keeps start high
  // into the next beat without a drop).
  task automatic send_cmd(logic [1:0] f, logic [VW-1:0] a, logic [VW-1:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    start <= 1'b1;
    in_func <= f;
    in_vertex_a <= a;
    in_vertex_b <= b;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain every expected beat, let the block settle, then write the mode.
  task automatic set_mode(logic m);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_search_mode <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // After a clear, a random mix of adds, searches, clears and unused codes; mostly well-formed, sized so lists fill.
  task automatic random_phase(int n, int span);
    int k, r;
    send_cmd(FUNC_CLEAR, $urandom, $urandom);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_cmd(FUNC_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1));
      else if (r < 90)
        send_cmd(FUNC_SEARCH, $urandom_range(0, span - 1), $urandom_range(0, span - 1));
      else if (r < 94)
        send_cmd(FUNC_CLEAR, $urandom, $urandom);
      else if (r < 97)
        send_cmd(FUNC_RSVD, $urandom, $urandom);
      else
        send_cmd(FUNC_SEARCH, $urandom, $urandom);
    end
  endtask

  initial begin
    int k;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, self loop, duplicate, full list, unused code, same vertex.
    send_cmd(FUNC_ADD, 0, 15);
    send_cmd(FUNC_ADD, 15, 0);
    send_cmd(FUNC_ADD, 15, 15);
    send_cmd(FUNC_ADD, 0, 15);
    send_cmd(FUNC_SEARCH, 0, 15);
    send_cmd(FUNC_SEARCH, 15, 0);
    send_cmd(FUNC_SEARCH, 7, 7);
    send_cmd(FUNC_SEARCH, 0, 9);
    send_cmd(FUNC_RSVD, 5, 10);
    for (k = 0; k < 9; k++) send_cmd(FUNC_ADD, 5, k);
    send_cmd(FUNC_SEARCH, 5, 8);
    send_cmd(FUNC_CLEAR, 15, 15);
    send_cmd(FUNC_SEARCH, 0, 15);

    // A 16-vertex chain gives the longest path; searched in both modes.
    set_mode(1'b1);
    for (k = 0; k < 15; k++) send_cmd(FUNC_ADD, k, k + 1);
    send_cmd(FUNC_SEARCH, 0, 15);
    set_mode(1'b0);
    send_cmd(FUNC_SEARCH, 0, 15);

    random_phase(80, 16);
    set_mode(1'b1);
    random_phase(80, 16);
    set_mode(1'b0);
    random_phase(80, 6);
    set_mode(1'b1);
    random_phase(80, 6);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### files.f
design/gps_pkg.sv
design/gps_ram.sv
design/gps_ctrl.sv
design/gps_dpath.sv
design/graph_path_search_unit.sv
verif/gps_checker.sv
verif/tb_graph_path_search_unit.sv
